@@ rtl/bounded_subset_search_macros.svh @@
// assertion macros shared by the bounded subset search checker
`ifndef BOUNDED_SUBSET_SEARCH_MACROS_SVH
`define BOUNDED_SUBSET_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bss_pkg.sv @@
// types and constants of the bounded subset search block
`timescale 1ns / 1ps

package bss_pkg;

    localparam int N_ITEMS  = 8;
    localparam int MASK_W   = N_ITEMS;
    localparam int IDX_W    = 3;
    localparam int PRICE_W  = 8;
    localparam int QTY_W    = 8;
    localparam int COST_W   = 16;
    localparam int HALF_N   = N_ITEMS / 2;
    localparam int HALF_W   = COST_W + $clog2(N_ITEMS - HALF_N + 1);
    localparam int SUM_W    = 20;
    localparam int CNT_W    = 4;
    localparam int BUDGET_W = 20;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [MASK_W-1:0] MASK_MAX = {MASK_W{1'b1}};

    // register index, taken from paddr[2]
    localparam logic REG_MAX_TYPES = 1'b0;
    localparam logic REG_BUDGET    = 1'b1;

    localparam logic [CNT_W-1:0]    MAX_TYPES_RST = CNT_W'(4);
    localparam logic [BUDGET_W-1:0] BUDGET_RST    = BUDGET_W'(19);

    typedef logic [N_ITEMS-1:0][COST_W-1:0] cost_tbl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } seq_state_t;

    // mask handed to the evaluator
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [MASK_W-1:0] mask;
    } issue_t;

    // evaluator verdict on one mask
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              hit;
        logic [MASK_W-1:0] mask;
        logic [SUM_W-1:0]  cost;
        logic [CNT_W-1:0]  count;
    } eval_t;

endpackage

@@ rtl/bounded_subset_search.sv @@
// bounded subset search: cost table, register port and mask scan sequencer
`timescale 1ns / 1ps

// A load item (op = 0) writes price times quantity, cut to 16 bits, into table
// entry item_index in the cycle it is accepted; it gives no result and busy
// stays low, so items may follow every cycle. A search item (op = 1) scans
// subset masks upward from start_mask, one mask per cycle through a shared
// evaluator (masked cost sum plus member count, then compare against budget
// and max_types), and stops at the first mask that fits. The result comes on
// done for exactly one cycle and cannot be held off by the receiver. From 1 up
// to 256 - start_mask masks are examined; the mask counter, the evaluator's
// register stage and the done register lie between acceptance and done. busy is
// high from the edge after acceptance until done rises; a new item may start in
// the done cycle. When no subset fits, found and all result fields read 0. A
// search over a table entry never loaded since reset gives an arbitrary answer.
// max_types and budget sit at byte addresses 0 and 4 of the register port and
// should only be written while the block is idle.

module bounded_subset_search
    import bss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [IDX_W-1:0]    item_index,
    input  logic [PRICE_W-1:0]  unit_price,
    input  logic [QTY_W-1:0]    quantity,
    input  logic [MASK_W-1:0]   start_mask,
    // result side
    output logic                done,
    output logic                found,
    output logic [MASK_W-1:0]   subset_mask,
    output logic [SUM_W-1:0]    total_cost,
    output logic [CNT_W-1:0]    item_count
);

    // configuration registers
    logic [CNT_W-1:0]    max_types_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic                cfg_wr;

    // cost table, no reset: entries are defined once loaded
    cost_tbl_t           cost_tbl_reg;
    logic [COST_W-1:0]   load_cost;

    // sequencer
    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [MASK_W-1:0]   mask_reg;
    logic                scan_en;
    logic                accept;
    logic                accept_search;
    logic                accept_load;

    // evaluator link
    issue_t              issue;
    eval_t               verdict;
    logic                emit;

    // result registers
    logic                done_reg;
    logic                found_reg;
    logic [MASK_W-1:0]   subset_mask_reg;
    logic [SUM_W-1:0]    total_cost_reg;
    logic [CNT_W-1:0]    item_count_reg;

    assign accept        = start && !busy;
    assign accept_search = accept && op;
    assign accept_load   = accept && !op;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_types_reg <= MAX_TYPES_RST;
            budget_reg    <= BUDGET_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MAX_TYPES: max_types_reg <= pwdata[CNT_W-1:0];
                REG_BUDGET:    budget_reg    <= pwdata[BUDGET_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_TYPES: prdata = PDATA_W'(max_types_reg);
            REG_BUDGET:    prdata = PDATA_W'(budget_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- cost table ----------------
    // 8x8 product fits 16 bits exactly
    assign load_cost = COST_W'(unit_price) * COST_W'(quantity);

    always_ff @(posedge clk)
    begin
        if (accept_load && (32'(item_index) < N_ITEMS))
            cost_tbl_reg[item_index] <= load_cost;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // a verdict leaves the evaluator when it fits or when it is the last mask
    assign emit = verdict.valid && (verdict.hit || verdict.last);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_search)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (emit)
                    state_next = ST_IDLE;
                else if (mask_reg == MASK_MAX)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (emit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        scan_en = 1'b0;
        busy    = 1'b1;
        unique case (state_reg)
            ST_IDLE: busy    = 1'b0;
            ST_SCAN: scan_en = 1'b1;
            ST_WAIT: ;
            default: busy    = 1'b0;
        endcase
    end

    // mask counter; masks still in flight after a hit are dropped
    always_ff @(posedge clk)
    begin
        if (accept_search)
            mask_reg <= start_mask;
        else if (scan_en)
            mask_reg <= mask_reg + MASK_W'(1);
    end

    always_comb
    begin
        issue.valid = scan_en && !emit;
        issue.last  = (mask_reg == MASK_MAX);
        issue.mask  = mask_reg;
    end

    bss_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .cost_tbl  (cost_tbl_reg),
        .max_types (max_types_reg),
        .budget    (budget_reg),
        .verdict   (verdict)
    );

    // ---------------- result ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= emit;
    end

    // nothing found gives all-zero fields
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg       <= verdict.hit;
            subset_mask_reg <= verdict.hit ? verdict.mask  : '0;
            total_cost_reg  <= verdict.hit ? verdict.cost  : '0;
            item_count_reg  <= verdict.hit ? verdict.count : '0;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign subset_mask = subset_mask_reg;
    assign total_cost  = total_cost_reg;
    assign item_count  = item_count_reg;

endmodule

@@ rtl/bss_eval.sv @@
// shared subset evaluator: masked cost sum and member count, then budget check
`timescale 1ns / 1ps

module bss_eval
    import bss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  issue_t              issue,
    input  cost_tbl_t           cost_tbl,
    input  logic [CNT_W-1:0]    max_types,
    input  logic [BUDGET_W-1:0] budget,
    output eval_t               verdict
);

    logic              valid_reg;
    logic              last_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [HALF_W-1:0] sum_a_reg;
    logic [HALF_W-1:0] sum_b_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [HALF_W-1:0] sum_a_next;
    logic [HALF_W-1:0] sum_b_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [HALF_W:0]   total;

    // item j sits at mask bit N_ITEMS-1-j; two half sums keep the adder chain short
    always_comb
    begin
        sum_a_next = '0;
        sum_b_next = '0;
        cnt_next   = '0;
        for (int i = 0; i < HALF_N; i++)
        begin
            if (issue.mask[MASK_W-1-i])
                sum_a_next = sum_a_next + HALF_W'(cost_tbl[i]);
        end
        for (int i = HALF_N; i < N_ITEMS; i++)
        begin
            if (issue.mask[MASK_W-1-i])
                sum_b_next = sum_b_next + HALF_W'(cost_tbl[i]);
        end
        for (int i = 0; i < MASK_W; i++)
        begin
            cnt_next = cnt_next + CNT_W'(issue.mask[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= issue.valid;
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= issue.last;
        mask_reg  <= issue.mask;
        sum_a_reg <= sum_a_next;
        sum_b_reg <= sum_b_next;
        cnt_reg   <= cnt_next;
    end

    assign total = {1'b0, sum_a_reg} + {1'b0, sum_b_reg};

    always_comb
    begin
        verdict.valid = valid_reg;
        verdict.last  = last_reg;
        verdict.mask  = mask_reg;
        verdict.cost  = SUM_W'(total);
        verdict.count = cnt_reg;
        verdict.hit   = valid_reg && (cnt_reg <= max_types)
                        && (SUM_W'(total) <= SUM_W'(budget));
    end

endmodule

@@ rtl/bss_checker.sv @@
// port-level checker for the bounded subset search block, with its bind
`timescale 1ns / 1ps
`include "bounded_subset_search_macros.svh"

module bss_checker
    import bss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              op,
    input logic              done,
    input logic              found,
    input logic [MASK_W-1:0] subset_mask,
    input logic [SUM_W-1:0]  total_cost,
    input logic [CNT_W-1:0]  item_count
);

    // the sequencer is back in idle when a result shows
    `BSS_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")

    // an accepted search occupies the block
    `BSS_ASSERT_NEXT(a_search_busy, start && !busy && op, busy, "search did not start")

    // a load never produces a result
    `BSS_ASSERT_NEXT(a_load_quiet, start && !busy && !op, !done, "load gave a result")

    // a miss carries all-zero fields
    `BSS_ASSERT_SAME(a_miss_zero, done && !found,
        (subset_mask == '0) && (total_cost == '0) && (item_count == '0),
        "miss with nonzero fields")

endmodule

bind bounded_subset_search bss_checker u_bss_checker (.*);

@@ sim/bounded_subset_search_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the bounded subset search block
module bounded_subset_search_test;
    import bss_pkg::*;

    // command codes carried on op
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // the run limit leaves a wide margin over a full scan from mask 0
    localparam int RUN_LIMIT     = 2_000_000;
    localparam int SCAN_LATENCY  = 260;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 128;

    // one command item as the sender sees it
    typedef struct {
        logic               op;
        logic [IDX_W-1:0]   index;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [MASK_W-1:0]  from_mask;
    } command_t;

    // the answer a search is expected to give
    typedef struct {
        logic              found;
        logic [MASK_W-1:0] mask;
        logic [SUM_W-1:0]  cost;
        logic [CNT_W-1:0]  count;
    } fit_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                start      = 1'b0;
    logic                busy;
    logic                op         = OP_LOAD;
    logic [IDX_W-1:0]    item_index = '0;
    logic [PRICE_W-1:0]  unit_price = '0;
    logic [QTY_W-1:0]    quantity   = '0;
    logic [MASK_W-1:0]   start_mask = '0;
    logic                done;
    logic                found;
    logic [MASK_W-1:0]   subset_mask;
    logic [SUM_W-1:0]    total_cost;
    logic [CNT_W-1:0]    item_count;

    // predictor state: its own copy of the cost table and both registers
    logic [COST_W-1:0]   cost_table_model [N_ITEMS];
    logic [CNT_W-1:0]    cfg_max_types = MAX_TYPES_RST;
    logic [BUDGET_W-1:0] cfg_budget    = BUDGET_RST;

    // answers of accepted searches, oldest first
    fit_t pending_fits [$];
    fit_t fit_now;
    int   mismatches  = 0;
    int   cycle_count = 0;

    bounded_subset_search dut (.*);

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // walk masks upward from from_mask; item j sits at mask bit N_ITEMS-1-j
    function automatic fit_t first_fit(input logic [MASK_W-1:0] from_mask);
        fit_t        answer;
        int          m;
        int          j;
        int unsigned cost_sum;
        int unsigned members;
        answer.found = 1'b0;
        answer.mask  = '0;
        answer.cost  = '0;
        answer.count = '0;
        for (m = from_mask; m < (1 << N_ITEMS) && !answer.found; m++) begin
            cost_sum = 0;
            members  = 0;
            for (j = 0; j < N_ITEMS; j++) begin
                if (m[N_ITEMS-1-j]) begin
                    cost_sum += cost_table_model[j];
                    members++;
                end
            end
            if (members <= cfg_max_types && cost_sum <= cfg_budget) begin
                answer.found = 1'b1;
                answer.mask  = MASK_W'(m);
                answer.cost  = SUM_W'(cost_sum);
                answer.count = CNT_W'(members);
            end
        end
        return answer;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_value(input string what, input logic [PDATA_W-1:0] want,
                               input logic [PDATA_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // the receiver cannot stall, so every done cycle is one accepted result
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (pending_fits.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got found %0d mask %0d",
                         $time, found, subset_mask);
            end else begin
                fit_now = pending_fits.pop_front();
                check_value("found", fit_now.found, found);
                check_value("subset_mask", fit_now.mask, subset_mask);
                check_value("total_cost", fit_now.cost, total_cost);
                check_value("item_count", fit_now.count, item_count);
            end
        end
    end

    // hang guard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    function automatic command_t make_load(input int index, input int price, input int qty);
        command_t cmd;
        cmd.op        = OP_LOAD;
        cmd.index     = IDX_W'(index);
        cmd.price     = PRICE_W'(price);
        cmd.qty       = QTY_W'(qty);
        // start_mask is don't-care for a load, so fill it with noise
        cmd.from_mask = MASK_W'($urandom());
        return cmd;
    endfunction

    function automatic command_t make_search(input int from_mask);
        command_t cmd;
        cmd.op        = OP_SEARCH;
        // load fields are don't-care for a search
        cmd.index     = IDX_W'($urandom());
        cmd.price     = PRICE_W'($urandom());
        cmd.qty       = QTY_W'($urandom());
        cmd.from_mask = MASK_W'(from_mask);
        return cmd;
    endfunction

    // raises start and leaves it high, so the next item can follow back to back;
    // the caller lowers it when a gap is wanted
    task automatic send_item(input command_t cmd);
        start      <= 1'b1;
        op         <= cmd.op;
        item_index <= cmd.index;
        unit_price <= cmd.price;
        quantity   <= cmd.qty;
        start_mask <= cmd.from_mask;
        do @(posedge clk); while (busy);
        // accepted at this edge: the table and registers as they stand now apply
        if (cmd.op == OP_LOAD)
            cost_table_model[cmd.index] = cmd.price * cmd.qty;
        else
            pending_fits.push_back(first_fit(cmd.from_mask));
    endtask

    // hold the sender off until every pending search has answered
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (pending_fits.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    // setup cycle then access cycle; pready is always high
    task automatic apb_access(input logic is_write, input logic reg_sel,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [PDATA_W-1:0] readback;
        apb_access(1'b0, REG_MAX_TYPES, '0, readback);
        check_value("max_types readback", PDATA_W'(cfg_max_types), readback);
        apb_access(1'b0, REG_BUDGET, '0, readback);
        check_value("budget readback", PDATA_W'(cfg_budget), readback);
    endtask

    // only the low field bits count; the words may carry noise above them
    task automatic apply_settings(input logic [PDATA_W-1:0] types_word,
                                  input logic [PDATA_W-1:0] budget_word);
        logic [PDATA_W-1:0] unused;
        wait_for_results();
        // loads finish in their accept cycle, so a short pause leaves the block idle
        repeat (4) @(posedge clk);
        apb_access(1'b1, REG_MAX_TYPES, types_word, unused);
        cfg_max_types = types_word[CNT_W-1:0];
        apb_access(1'b1, REG_BUDGET, budget_word, unused);
        cfg_budget = budget_word[BUDGET_W-1:0];
        check_registers();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic reset_dut();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_register_reset();
        check_registers();
    endtask

    // every entry is loaded before any search, so no search reads an unwritten entry;
    // the values cover zero price, zero quantity, the largest product and all bits
    task automatic test_table_loads();
        logic [PRICE_W-1:0] prices [N_ITEMS] = '{255, 0, 255, 3, 1, 2, 170, 85};
        logic [QTY_W-1:0]   qtys   [N_ITEMS] = '{255, 255, 0, 5, 4, 2, 85, 170};
        int i;
        for (i = 0; i < N_ITEMS; i++)
            send_item(make_load(i, prices[i], qtys[i]));
    endtask

    task automatic test_search_corners();
        // reset settings: empty subset at the start, the full mask, nothing found
        send_item(make_search(0));
        send_item(make_search(1));
        send_item(make_search(8'h80));
        send_item(make_search(8'h7F));
        send_item(make_search(8'hFF));
        // max_types of zero admits only the empty subset; noise above the field
        apply_settings(32'hFFFF_FFF0, 32'h000F_FFFF);
        send_item(make_search(0));
        send_item(make_search(1));
        // max_types above N_ITEMS never limits, widest budget takes the full mask
        apply_settings(32'h0000_000F, 32'hFFFF_FFFF);
        send_item(make_search(8'hFF));
        send_item(make_search(8'hC0));
        // zero budget: only zero-cost members may be picked
        apply_settings(32'h0000_0008, 32'h0000_0000);
        send_item(make_search(1));
        send_item(make_search(8'h21));
        // budget just above the largest single cost, two members at most
        apply_settings(32'h0000_0002, 32'h0001_0000);
        send_item(make_search(8'h80));
    endtask

    // mostly a full range of masks, with extra weight at zero and at the top end
    function automatic int pick_start();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(240, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic run_random_phase(input int n_items, input int cap, input bit steady);
        int i;
        int burst_left;
        burst_left = $urandom_range(1, 16);
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 40)
                send_item(make_load($urandom_range(0, N_ITEMS - 1),
                                    $urandom_range(0, cap), $urandom_range(0, cap)));
            else
                send_item(make_search(pick_start()));
            if ($urandom_range(0, 149) == 0) begin
                // drain completely now and then, then pick up again
                wait_for_results();
            end else if (!steady) begin
                burst_left--;
                if (burst_left == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                    burst_left = $urandom_range(1, 16);
                end
            end
        end
    endtask

    // each phase picks settings, a cost scale for its loads and an idling style
    task automatic test_random_traffic();
        int                  p;
        int                  cap;
        logic [CNT_W-1:0]    types;
        logic [BUDGET_W-1:0] limit_cost;
        logic [PDATA_W-1:0]  types_word;
        logic [PDATA_W-1:0]  budget_word;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       types = '0;
                1:       types = '1;
                2:       types = CNT_W'(N_ITEMS);
                default: types = CNT_W'($urandom_range(0, 15));
            endcase
            case (p % 5)
                0:       limit_cost = '0;
                1:       limit_cost = '1;
                2:       limit_cost = BUDGET_W'($urandom_range(0, 600));
                3:       limit_cost = BUDGET_W'($urandom_range(0, 20000));
                default: limit_cost = BUDGET_W'($urandom_range(0, 1048575));
            endcase
            case (p % 3)
                0:       cap = 7;
                1:       cap = 31;
                default: cap = 255;
            endcase
            types_word  = $urandom();
            types_word[CNT_W-1:0] = types;
            budget_word = $urandom();
            budget_word[BUDGET_W-1:0] = limit_cost;
            apply_settings(types_word, budget_word);
            // one phase runs without the random gaps between bursts; only the occasional drain remains
            run_random_phase(PHASE_ITEMS, cap, p == 3);
        end
    endtask

    initial begin
        reset_dut();
        test_register_reset();
        test_table_loads();
        test_search_corners();
        test_random_traffic();
        wait_for_results();
        // room for any stray result of a full scan
        repeat (SCAN_LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ bounded_subset_search.f @@
+incdir+rtl
rtl/bss_pkg.sv
rtl/bss_eval.sv
rtl/bounded_subset_search.sv
rtl/bss_checker.sv
sim/bounded_subset_search_test.sv
